@@ rtl/cvd_pkg.sv @@
// ----------------------------------------------------------------------------
// cvd_pkg
// Shared constants of the capacitive divider touch detector.
// ----------------------------------------------------------------------------
package cvd_pkg;

  // Debounce counter and limit register
  localparam int unsigned DBNC_W = 8;
  localparam logic [DBNC_W-1:0] DBNC_MAX = '1;
  localparam logic [DBNC_W-1:0] DBNC_LIMIT_RESET = 8'd2;

  typedef logic [DBNC_W-1:0] dbnc_t;

endpackage : cvd_pkg

@@ rtl/cvd_ram.sv @@
// ----------------------------------------------------------------------------
// cvd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cvd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule : cvd_ram

@@ rtl/cvd_touch_detector.sv @@
// ----------------------------------------------------------------------------
// cvd_touch_detector
// Capacitive voltage divider touch detector with calibration and debounce.
// ----------------------------------------------------------------------------
// Each input request carries the two conversions of one sensor and a debounce
// timer overflow flag; each one yields exactly one output request in the cycle
// after it is accepted. The block accepts one request per clock cycle,
// continuously, as long as the output side takes results; a result waiting in
// the output register does not stop the next request when out_ready is high.
// After reset the block calibrates: for 2^CAL_ROUNDS_LOG2 rounds over all
// sensors it accumulates each sensor's sum and maximum measurement. It then
// switches to detection, where a sensor counts as touched when its measurement
// exceeds max + (max - avg) / 2, and a changed state is taken over only once
// enough pending timer ticks have pushed the debounce count past cfg_wr_data's
// limit. Per-sensor state (sum, max, stable touch state) lives in a small RAM
// with a registered read. The read address always follows the next selected
// sensor, so the entry of the current sensor is ready when its request
// arrives; a forwarding register covers a write that is followed at once by a
// read of the same entry. A valid bit per entry makes unwritten entries read
// as zero, so there is no clearing pass after reset. The touch threshold is
// derived from the stored sum and max on each detection request, not stored.
// ----------------------------------------------------------------------------
module cvd_touch_detector #(
  parameter int unsigned SENSOR_COUNT    = 4,
  parameter int unsigned CAL_ROUNDS_LOG2 = 7,
  parameter int unsigned SAMPLE_BITS     = 10
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  // configuration
  input  logic                                               cfg_wr_en,
  input  cvd_pkg::dbnc_t                                     cfg_wr_data,
  // input requests
  input  logic                                               in_valid,
  output logic                                               in_ready,
  input  logic [SAMPLE_BITS-1:0]                             in_first_sample,
  input  logic [SAMPLE_BITS-1:0]                             in_second_sample,
  input  logic                                               in_timer_tick,
  // output requests
  output logic                                               out_valid,
  input  logic                                               out_ready,
  output logic [((SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1)-1:0] out_led_index,
  output logic                                               out_led_on,
  output logic                                               out_calibrating,
  output logic [SAMPLE_BITS:0]                               out_difference
);

  import cvd_pkg::*;

  localparam int unsigned IDX_W  = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int unsigned DIFF_W = SAMPLE_BITS + 1;
  localparam int unsigned SUM_W  = DIFF_W + CAL_ROUNDS_LOG2;
  localparam int unsigned THR_W  = DIFF_W + 1;

  localparam logic [IDX_W-1:0]           LAST_SENSOR = IDX_W'(SENSOR_COUNT - 1);
  localparam logic [CAL_ROUNDS_LOG2-1:0] LAST_ROUND  = '1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [DIFF_W-1:0] max;
    logic              stable;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  dbnc_t                      limit_r;
  logic                       cal_r, cal_nxt;
  logic [CAL_ROUNDS_LOG2-1:0] round_r, round_nxt;
  idx_t                       sensor_r, sensor_nxt;
  dbnc_t                      cnt_r, cnt_nxt;
  logic                       tick_r, tick_nxt;
  logic [SENSOR_COUNT-1:0]    valid_r;
  logic                       fwd_r;
  entry_t                     fwd_data_r;

  logic                       out_valid_r;
  idx_t                       out_led_index_r, out_led_index_nxt;
  logic                       out_calibrating_r;
  logic [DIFF_W-1:0]          out_difference_r;

  // --------------------------------------------------------------------------
  // Entry memory
  // --------------------------------------------------------------------------
  logic                 ram_we;
  entry_t               ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  entry_t               entry;

  cvd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SENSOR_COUNT)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sensor_r),
    .wdata (ram_wdata),
    .raddr (sensor_nxt),
    .rdata (ram_rdata)
  );

  // Current sensor's entry: forwarded write, stored data, or zero if unwritten
  always_comb begin
    if (fwd_r) begin
      entry = fwd_data_r;
    end else if (valid_r[sensor_r]) begin
      entry = entry_t'(ram_rdata);
    end else begin
      entry = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Request processing
  // --------------------------------------------------------------------------
  logic              accept;
  logic [DIFF_W-1:0] diff;
  idx_t              sensor_next;
  logic              tick_all;
  logic [DIFF_W-1:0] avg;
  logic [DIFF_W-1:0] spread;
  logic [THR_W-1:0]  thr;
  logic              status;
  dbnc_t             cnt_tick;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // second + 2^SAMPLE_BITS - first, kept to DIFF_W bits
  assign diff = DIFF_W'({1'b1, in_second_sample} - {1'b0, in_first_sample});

  assign sensor_next = (sensor_r == LAST_SENSOR) ? '0 : sensor_r + idx_t'(1);
  assign tick_all    = tick_r | in_timer_tick;

  // Threshold: max + (max - avg) / 2
  assign avg    = DIFF_W'(entry.sum >> CAL_ROUNDS_LOG2);
  assign spread = (entry.max >= avg) ? (entry.max - avg) : '0;
  assign thr    = {1'b0, entry.max} + {2'b00, spread[DIFF_W-1:1]};
  assign status = {1'b0, diff} > thr;

  assign cnt_tick = (tick_all && cnt_r != DBNC_MAX) ? cnt_r + dbnc_t'(1) : cnt_r;

  always_comb begin
    cal_nxt           = cal_r;
    round_nxt         = round_r;
    sensor_nxt        = sensor_r;
    cnt_nxt           = cnt_r;
    tick_nxt          = tick_r;
    ram_we            = 1'b0;
    ram_wdata         = entry;
    out_led_index_nxt = sensor_r;

    if (accept) begin
      tick_nxt = tick_all;
      if (cal_r) begin
        // accumulate sum and max, step round-robin
        ram_we        = 1'b1;
        ram_wdata.sum = entry.sum + SUM_W'(diff);
        if (diff > entry.max) begin
          ram_wdata.max = diff;
        end
        sensor_nxt = sensor_next;
        if (sensor_r == LAST_SENSOR) begin
          if (round_r == LAST_ROUND) begin
            round_nxt = '0;
            cal_nxt   = 1'b0;
          end else begin
            round_nxt = round_r + 1'b1;
          end
        end
      end else if (status != entry.stable) begin
        // changed state: consume a pending tick, accept once past the limit
        if (tick_all) begin
          tick_nxt = 1'b0;
        end
        cnt_nxt = cnt_tick;
        if (cnt_tick > limit_r) begin
          ram_we           = 1'b1;
          ram_wdata.stable = status;
          cnt_nxt          = '0;
        end
      end else begin
        // stable: reset debounce and advance
        cnt_nxt           = '0;
        sensor_nxt        = sensor_next;
        out_led_index_nxt = sensor_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= DBNC_LIMIT_RESET;
      cal_r       <= 1'b1;
      round_r     <= '0;
      sensor_r    <= '0;
      cnt_r       <= '0;
      tick_r      <= 1'b0;
      valid_r     <= '0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      cal_r    <= cal_nxt;
      round_r  <= round_nxt;
      sensor_r <= sensor_nxt;
      cnt_r    <= cnt_nxt;
      tick_r   <= tick_nxt;
      if (ram_we) begin
        valid_r[sensor_r] <= 1'b1;
      end
      // forward when the entry just written is the one read next
      fwd_r <= ram_we && (sensor_nxt == sensor_r);
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    fwd_data_r <= ram_wdata;
    if (accept) begin
      out_led_index_r   <= out_led_index_nxt;
      out_calibrating_r <= cal_r;
      out_difference_r  <= diff;
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  // In detection the shown sensor is always the current one, so its stable
  // state is the entry view; during calibration every stable state is still untouched.
  assign out_valid       = out_valid_r;
  assign out_led_index   = out_led_index_r;
  assign out_led_on      = out_calibrating_r ? 1'b0 : entry.stable;
  assign out_calibrating = out_calibrating_r;
  assign out_difference  = out_difference_r;

endmodule : cvd_touch_detector
